@@ sv/sampled_event_profile_counters_assert.svh @@
// Assertion macros used by the profile counter controller.
`ifndef SAMPLED_EVENT_PROFILE_COUNTERS_ASSERT_SVH
`define SAMPLED_EVENT_PROFILE_COUNTERS_ASSERT_SVH

`ifndef ASSERT_OFF

// Checked on clk, muted while rst is high.
`define SEPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on clk, also during reset.
`define SEPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SEPC_ASSERT(lbl, prop, msg)
`define SEPC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ sv/sepc_pkg.sv @@
// Shared types and constants of the sampled event profile counters.
`default_nettype none

package sepc_pkg;

  // Bank geometry
  localparam int NUM_EVENTS    = 21;
  localparam int SAMPLE_PERIOD = 16;
  localparam int IDX_W         = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
  localparam int PHASE_W       = (SAMPLE_PERIOD > 1) ? $clog2(SAMPLE_PERIOD) : 1;

  // Field widths
  localparam int LEVEL_W = 2;
  localparam int MASK_W  = 21;
  localparam int OP_W    = 3;
  localparam int EID_W   = 5;
  localparam int CNT_W   = 64;

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_LEVEL = 2'd0;
  localparam logic [1:0] REG_SMASK = 2'd1;
  localparam logic [1:0] REG_TMASK = 2'd2;

  localparam logic [LEVEL_W-1:0] LEVEL_RST = 2'd0;
  localparam logic [MASK_W-1:0]  SMASK_RST = 21'd1712266;
  localparam logic [MASK_W-1:0]  TMASK_RST = 21'd506303;

  localparam logic [LEVEL_W-1:0] LVL_SUMMARY = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_DETAIL  = 2'd2;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_START  = 3'd0,
    OP_END    = 3'd1,
    OP_COUNT  = 3'd2,
    OP_RECORD = 3'd3,
    OP_READ   = 3'd4
  } sepc_op_t;

  // One event's counters
  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   total;
    logic [CNT_W-1:0]   maxv;
    logic [CNT_W-1:0]   bytes;
    logic [PHASE_W-1:0] phase;
  } sepc_entry_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [MASK_W-1:0]  smask;
    logic [MASK_W-1:0]  tmask;
  } sepc_cfg_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } sepc_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic commit;
  } sepc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } sepc_stat_t;

endpackage

`default_nettype wire

@@ sv/sepc_req_if.sv @@
// Input channel: one profiling operation per transfer.
`default_nettype none

interface sepc_req_if import sepc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [EID_W-1:0]   event_id;
  logic [CNT_W-1:0]   now_ns;
  logic [CNT_W-1:0]   start_stamp;
  logic [CNT_W-1:0]   record_ns;
  logic [CNT_W-1:0]   byte_amount;
  logic [CNT_W-1:0]   event_amount;

  modport source (
    output valid, opcode, event_id, now_ns, start_stamp, record_ns, byte_amount,
           event_amount,
    input  ready
  );

  modport sink (
    input  valid, opcode, event_id, now_ns, start_stamp, record_ns, byte_amount,
           event_amount,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/sepc_rsp_if.sv @@
// Output channel: one counter snapshot per transfer.
`default_nettype none

interface sepc_rsp_if import sepc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] stamp_out;
  logic [CNT_W-1:0] count_out;
  logic [CNT_W-1:0] total_out;
  logic [CNT_W-1:0] max_out;
  logic [CNT_W-1:0] bytes_out;
  logic             applied;

  modport source (
    output valid, stamp_out, count_out, total_out, max_out, bytes_out, applied,
    input  ready
  );

  modport sink (
    input  valid, stamp_out, count_out, total_out, max_out, bytes_out, applied,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/sepc_regs.sv @@
// APB configuration registers: profile level and the two event masks.
`default_nettype none

module sepc_regs import sepc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output sepc_cfg_t               cfg
);

  logic       wr;
  logic [1:0] sel;

  assign pready = 1'b1;
  assign sel    = paddr[3:2];
  assign wr     = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level <= LEVEL_RST;
      cfg.smask <= SMASK_RST;
      cfg.tmask <= TMASK_RST;
    end else if (wr) begin
      case (sel)
        REG_LEVEL: cfg.level <= pwdata[LEVEL_W-1:0];
        REG_SMASK: cfg.smask <= pwdata[MASK_W-1:0];
        REG_TMASK: cfg.tmask <= pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (sel)
      REG_LEVEL: prdata = PDATA_W'(cfg.level);
      REG_SMASK: prdata = PDATA_W'(cfg.smask);
      REG_TMASK: prdata = PDATA_W'(cfg.tmask);
      default:   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/sepc_ctrl.sv @@
// Controller: sequences accept, execute and commit of one operation.
`default_nettype none
`include "sampled_event_profile_counters_assert.svh"

module sepc_ctrl import sepc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  input  sepc_stat_t      stat,
  output sepc_cmd_t       cmd
);

  sepc_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = !rst;
        if (req_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `SEPC_ASSERT(a_load_then_exec, cmd.load |=> cmd.exec, "load not followed by execute")
  `SEPC_ASSERT(a_exec_then_done, cmd.exec |=> (state == S_DONE), "execute did not reach commit")
  `SEPC_ASSERT(a_commit_free, cmd.commit |-> stat.out_free, "commit into a full output register")
  `SEPC_ASSERT_ALWAYS(a_one_cmd, $onehot0({cmd.load, cmd.exec, cmd.commit}), "overlapping commands")

endmodule

`default_nettype wire

@@ sv/sepc_dpath.sv @@
// Datapath: counter memory, update arithmetic and output register.
`default_nettype none

module sepc_dpath import sepc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  sepc_cmd_t       cmd,
  input  sepc_cfg_t       cfg,
  output sepc_stat_t      stat,
  sepc_req_if.sink        req,
  sepc_rsp_if.source      rsp
);

  // Counter memory; an entry never written reads as zero
  sepc_entry_t             mem [NUM_EVENTS];
  logic [NUM_EVENTS-1:0]   filled;
  sepc_entry_t             rd_q;
  logic                    rd_ok;

  // Latched operation
  logic [OP_W-1:0]         op_q;
  logic [EID_W-1:0]        eid_q;
  logic [CNT_W-1:0]        now_q, stamp_in_q, elapsed_q, bytes_q, amount_q;

  // Execute results
  sepc_entry_t             nx_entry;
  logic [CNT_W-1:0]        nx_stamp;
  logic                    nx_applied, nx_hit;

  // Combinational update
  sepc_entry_t             cur, upd;
  logic                    req_hit, hit, en, tim, summary, do_cnt, do_time;
  logic [31:0]             smask_x, tmask_x;
  logic [LEVEL_W-1:0]      need;
  logic [CNT_W-1:0]        dur, dur_add, cnt_add, stamp;
  logic [PHASE_W:0]        phase_inc;
  logic                    applied;

  assign req_hit = {1'b0, req.event_id} < (EID_W + 1)'(NUM_EVENTS);
  assign hit     = {1'b0, eid_q} < (EID_W + 1)'(NUM_EVENTS);

  // Operand capture and memory read at accept
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q       <= req.opcode;
      eid_q      <= req.event_id;
      now_q      <= req.now_ns;
      stamp_in_q <= req.start_stamp;
      elapsed_q  <= req.record_ns;
      bytes_q    <= req.byte_amount;
      amount_q   <= req.event_amount;
      rd_q       <= mem[req.event_id[IDX_W-1:0]];
      rd_ok      <= req_hit && filled[req.event_id[IDX_W-1:0]];
    end
  end

  // Memory write-back
  always_ff @(posedge clk) begin
    if (cmd.commit && nx_hit) begin
      mem[eid_q[IDX_W-1:0]] <= nx_entry;
    end
  end

  // Written flags
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (cmd.commit && nx_hit) begin
      filled[eid_q[IDX_W-1:0]] <= 1'b1;
    end
  end

  // Update arithmetic
  always_comb begin
    cur       = rd_ok ? rd_q : '0;
    smask_x   = 32'(cfg.smask);
    tmask_x   = 32'(cfg.tmask);
    need      = smask_x[eid_q] ? LVL_SUMMARY : LVL_DETAIL;
    en        = cfg.level >= need;
    tim       = tmask_x[eid_q];
    summary   = cfg.level == LVL_SUMMARY;
    dur       = (op_q == OP_END) ? now_q - stamp_in_q : elapsed_q;
    dur_add   = (op_q == OP_END && summary) ? dur * CNT_W'(SAMPLE_PERIOD) : dur;
    cnt_add   = (op_q == OP_RECORD) ? amount_q : CNT_W'(1);
    phase_inc = {1'b0, cur.phase} + (PHASE_W + 1)'(1);
    upd       = cur;
    stamp     = '0;
    applied   = 1'b0;
    do_cnt    = 1'b0;
    do_time   = 1'b0;
    case (op_q)
      OP_START: begin
        if (en && tim) begin
          if (summary) begin
            // sampled: only every SAMPLE_PERIOD-th start hands out a stamp
            if (phase_inc >= (PHASE_W + 1)'(SAMPLE_PERIOD)) begin
              upd.phase = '0;
              stamp     = now_q;
            end else begin
              upd.phase = phase_inc[PHASE_W-1:0];
            end
          end else begin
            stamp = now_q;
          end
        end
      end
      OP_END: begin
        if (en && tim) begin
          do_cnt  = 1'b1;
          do_time = stamp_in_q != '0;
          applied = 1'b1;
        end
      end
      OP_COUNT: begin
        if (en && !tim) begin
          do_cnt  = 1'b1;
          applied = 1'b1;
        end
      end
      OP_RECORD: begin
        if (amount_q != '0 && en) begin
          do_cnt  = 1'b1;
          do_time = tim;
          applied = 1'b1;
        end
      end
      OP_READ: applied = 1'b1;
      default: ;
    endcase
    if (do_cnt) begin
      upd.count = cur.count + cnt_add;
      upd.bytes = cur.bytes + bytes_q;
    end
    if (do_time) begin
      upd.total = cur.total + dur_add;
      if ($signed(dur) > $signed(cur.maxv)) begin
        upd.maxv = dur;
      end
    end
    if (!hit) begin
      stamp   = '0;
      applied = 1'b0;
    end
  end

  // Execute register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      nx_entry   <= upd;
      nx_stamp   <= stamp;
      nx_applied <= applied;
      nx_hit     <= hit;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.stamp_out <= nx_stamp;
      rsp.count_out <= nx_hit ? nx_entry.count : '0;
      rsp.total_out <= nx_hit ? nx_entry.total : '0;
      rsp.max_out   <= nx_hit ? nx_entry.maxv : '0;
      rsp.bytes_out <= nx_hit ? nx_entry.bytes : '0;
      rsp.applied   <= nx_applied;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  assign stat.out_free = !rsp.valid || rsp.ready;

endmodule

`default_nettype wire

@@ sv/sampled_event_profile_counters.sv @@
// Sampled event profile counters: a bank of per-event count, time, maximum
// and byte counters updated by start, end, count, record and read operations.
// Each operation passes these steps from transfer to result: the accept edge
// reads the event's entry from the counter memory into a register, the
// execute step registers the updated entry, and the commit writes it back
// and loads the output register; the commit waits while the output
// register stays full. The next operation is taken while a result still
// waits in the output register. Counters read as zero after reset through
// per-entry written flags, so no clearing pass is needed.
`default_nettype none

module sampled_event_profile_counters import sepc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  sepc_req_if.sink                req,
  sepc_rsp_if.source              rsp
);

  sepc_cfg_t  cfg;
  sepc_cmd_t  cmd;
  sepc_stat_t stat;
  logic       req_ready;

  assign req.ready = req_ready;

  sepc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sepc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sepc_dpath u_dpath (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .cfg  (cfg),
    .stat (stat),
    .req  (req),
    .rsp  (rsp)
  );

endmodule

`default_nettype wire
